// File: sv/opposite_pair_clip_3x3_filter_defines.svh
// Assertion macros for the opposite-pair clip 3x3 filter.
// Needs clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef OPPOSITE_PAIR_CLIP_3X3_FILTER_DEFINES_SVH
`define OPPOSITE_PAIR_CLIP_3X3_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OPC3_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OPC3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/opc3_pkg.sv
// Shared constants of the opposite-pair clip 3x3 filter.
// No dependencies; used by the clip unit and the top level.
`timescale 1ns / 1ps

package opc3_pkg;

  // Row positions inside one column.
  localparam logic [1:0] COL_UPPER  = 2'd0;
  localparam logic [1:0] COL_MIDDLE = 2'd1;
  localparam logic [1:0] COL_LOWER  = 2'd2;

  // Columns of the current row taken so far (saturating).
  localparam int unsigned SeenBits = 2;
  localparam logic [SeenBits-1:0] SEEN_NONE = 2'd0;
  localparam logic [SeenBits-1:0] SEEN_ONE  = 2'd1;
  localparam logic [SeenBits-1:0] SEEN_MANY = 2'd2;

endpackage

// File: sv/opc3_stream_if.sv
// Valid/ready stream interfaces for column requests and result pixels.
// No dependencies.
`timescale 1ns / 1ps

interface opc3_in_if #(
  parameter int unsigned PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] upper_pixel;
  logic [PIXEL_BITS-1:0] middle_pixel;
  logic [PIXEL_BITS-1:0] lower_pixel;
  logic                  row_start;
  logic                  row_end;

  modport source (
    output valid, upper_pixel, middle_pixel, lower_pixel, row_start, row_end,
    input  ready
  );
  modport sink (
    input  valid, upper_pixel, middle_pixel, lower_pixel, row_start, row_end,
    output ready
  );
endinterface

interface opc3_out_if #(
  parameter int unsigned PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] out_pixel;
  logic                  last_of_row;

  modport source (
    output valid, out_pixel, last_of_row,
    input  ready
  );
  modport sink (
    input  valid, out_pixel, last_of_row,
    output ready
  );
endinterface

// File: sv/opposite_pair_clip_3x3_filter.sv
// Opposite-pair clip 3x3 filter, streamed one column of three pixels per request.
// Depends on opc3_pkg, opc3_stream_if, opc3_clip and the assertion macro header.
//
// Sustains one column per clock while the output queue has room: a column is held
// in an input register, then the clip network runs combinationally and up to two
// result pixels enter a four-entry output queue.
// in_i.ready drops only while the input register holds a column and the queue
// cannot take two more results; with the sink taking a pixel every clock the
// input never stalls. Row borders pass through unchanged.
`timescale 1ns / 1ps
`include "opposite_pair_clip_3x3_filter_defines.svh"

module opposite_pair_clip_3x3_filter #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  opc3_in_if.sink           in_i,
  opc3_out_if.source        out_o
);
  import opc3_pkg::*;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrBits   = $clog2(FifoDepth);
  localparam int unsigned CntBits   = $clog2(FifoDepth + 1);

  // Input register
  logic                         s1_valid_q;
  logic [2:0][PIXEL_BITS-1:0]   s1_col_q;
  logic                         s1_start_q, s1_end_q;

  // Window state
  logic [2:0][PIXEL_BITS-1:0]   left_q, centre_q;
  logic [SeenBits-1:0]          seen_q, seen_d, seen;

  // Output queue
  logic [PIXEL_BITS-1:0]        pix_q  [FifoDepth];
  logic                         last_q [FifoDepth];
  logic [PtrBits-1:0]           wr_q, rd_q, wr_next;
  logic [CntBits-1:0]           cnt_q;

  logic                         in_acc, pop, room, advance;
  logic [1:0]                   n_push;
  logic [PIXEL_BITS-1:0]        push_pix0, push_pix1, clip_pix;
  logic                         push_last0;

  opc3_clip #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_clip (
    .left_col_i   (left_q),
    .centre_col_i (centre_q),
    .right_col_i  (s1_col_q),
    .pixel_o      (clip_pix)
  );

  assign pop     = out_o.valid & out_o.ready;
  assign room    = pop ? (cnt_q <= CntBits'(FifoDepth - 1))
                       : (cnt_q <= CntBits'(FifoDepth - 2));
  assign advance = s1_valid_q & room;
  assign in_i.ready = !s1_valid_q || room;
  assign in_acc  = in_i.valid & in_i.ready;

  assign seen    = s1_start_q ? SEEN_NONE : seen_q;
  assign wr_next = wr_q + PtrBits'(1);

  always_comb begin
    n_push     = 2'd0;
    push_pix0  = s1_col_q[COL_MIDDLE];
    push_last0 = s1_end_q;
    push_pix1  = s1_col_q[COL_MIDDLE];
    unique case (seen)
      SEEN_NONE: begin
        n_push = 2'd1;
      end
      SEEN_ONE: begin
        n_push = s1_end_q ? 2'd1 : 2'd0;
      end
      default: begin
        push_pix0  = clip_pix;
        push_last0 = 1'b0;
        n_push     = s1_end_q ? 2'd2 : 2'd1;
      end
    endcase
    if (s1_end_q) begin
      seen_d = SEEN_NONE;
    end else if (seen == SEEN_NONE) begin
      seen_d = SEEN_ONE;
    end else begin
      seen_d = SEEN_MANY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q[COL_UPPER]  <= in_i.upper_pixel;
      s1_col_q[COL_MIDDLE] <= in_i.middle_pixel;
      s1_col_q[COL_LOWER]  <= in_i.lower_pixel;
      s1_start_q           <= in_i.row_start;
      s1_end_q             <= in_i.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      centre_q <= '0;
      seen_q   <= SEEN_NONE;
    end else if (advance) begin
      left_q   <= centre_q;
      centre_q <= s1_col_q;
      seen_q   <= seen_d;
    end
  end

  // Queue storage: first result at wr_q, second at wr_q + 1.
  always_ff @(posedge clk_i) begin
    if (advance && n_push != 2'd0) begin
      pix_q[wr_q]  <= push_pix0;
      last_q[wr_q] <= push_last0;
    end
    if (advance && n_push == 2'd2) begin
      pix_q[wr_next]  <= push_pix1;
      last_q[wr_next] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (advance) begin
        wr_q <= wr_q + PtrBits'(n_push);
      end
      if (pop) begin
        rd_q <= rd_q + PtrBits'(1);
      end
      cnt_q <= cnt_q + (advance ? CntBits'(n_push) : CntBits'(0)) - CntBits'(pop);
    end
  end

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_pixel   = pix_q[rd_q];
  assign out_o.last_of_row = last_q[rd_q];

  `OPC3_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CntBits'(FifoDepth), "output queue overflow")
  `OPC3_ASSERT(a_stall_held, !in_i.ready, s1_valid_q, "input stalled with empty register")
  `OPC3_ASSERT_NEXT(a_row_restart, advance && s1_end_q, seen_q == SEEN_NONE, "count kept")
  `OPC3_ASSERT_NEXT(a_push_room, advance, cnt_q <= CntBits'(FifoDepth), "pushed without room")

endmodule

// File: sv/opc3_clip.sv
// Opposite-pair clip: bounds from four neighbour pairs, clamp of the centre.
// Depends on opc3_pkg for the row positions inside a column.
`timescale 1ns / 1ps

module opc3_clip #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic [2:0][PIXEL_BITS-1:0] left_col_i,
  input  logic [2:0][PIXEL_BITS-1:0] centre_col_i,
  input  logic [2:0][PIXEL_BITS-1:0] right_col_i,
  output logic [PIXEL_BITS-1:0]      pixel_o
);
  import opc3_pkg::*;

  function automatic logic [PIXEL_BITS-1:0] min_f(
    input logic [PIXEL_BITS-1:0] a, input logic [PIXEL_BITS-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] max_f(
    input logic [PIXEL_BITS-1:0] a, input logic [PIXEL_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [3:0][PIXEL_BITS-1:0] pair_a, pair_b, pair_min, pair_max;
  logic [PIXEL_BITS-1:0]      hi, lo, bound_hi, bound_lo;

  // Opposite pairs: two diagonals, vertical, horizontal.
  assign pair_a[0] = left_col_i[COL_UPPER];
  assign pair_b[0] = right_col_i[COL_LOWER];
  assign pair_a[1] = centre_col_i[COL_UPPER];
  assign pair_b[1] = centre_col_i[COL_LOWER];
  assign pair_a[2] = right_col_i[COL_UPPER];
  assign pair_b[2] = left_col_i[COL_LOWER];
  assign pair_a[3] = left_col_i[COL_MIDDLE];
  assign pair_b[3] = right_col_i[COL_MIDDLE];

  for (genvar p = 0; p < 4; p++) begin : g_pair
    assign pair_min[p] = min_f(pair_a[p], pair_b[p]);
    assign pair_max[p] = max_f(pair_a[p], pair_b[p]);
  end

  assign hi = max_f(max_f(pair_min[0], pair_min[1]), max_f(pair_min[2], pair_min[3]));
  assign lo = min_f(min_f(pair_max[0], pair_max[1]), min_f(pair_max[2], pair_max[3]));

  assign bound_hi = (lo > hi) ? lo : hi;
  assign bound_lo = (lo > hi) ? hi : lo;

  assign pixel_o = max_f(min_f(centre_col_i[COL_MIDDLE], bound_hi), bound_lo);

endmodule
